/* design/wmm_pkg.sv */
// package for the window median block: request types, cell link types,
// register indexes and reset constants
// no dependencies
package wmm_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int VAL_W          = 16;
  localparam int CNT_OUT_W      = 9;

  localparam logic signed [VAL_W-1:0] FILL_RST  = -16'sd3000;
  localparam logic signed [VAL_W-1:0] EMPTY_RST = -16'sd3000;
  localparam logic [CNT_OUT_W-1:0]    MISS_MAX  = 9'd511;

  typedef enum logic [1:0] {
    CFG_MISSING_AS_LOW = 2'd0,
    CFG_FILL_VALUE     = 2'd1,
    CFG_EMPTY_VALUE    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_SEEK = 1'b1
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample;
    logic                    is_missing;
    logic                    last;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] median;
    logic [CNT_OUT_W-1:0]    stored_count;
    logic [CNT_OUT_W-1:0]    missing_count;
    logic                    overflow;
  } out_req_t;

  typedef struct packed {
    logic                    ins;
    logic                    shift;
    logic                    clr;
    logic signed [VAL_W-1:0] ins_val;
  } cell_ctrl_t;

  typedef struct packed {
    logic                    valid;
    logic                    gt;
    logic signed [VAL_W-1:0] val;
  } cell_link_t;

endpackage

/* design/wmm_cell.sv */
// one cell of the sorting chain: holds one value, keeps the chain ascending
// on insert and shifts toward cell zero while the median is sought
// depends on wmm_pkg
module wmm_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wmm_pkg::cell_ctrl_t          ctrl,
  input  wmm_pkg::cell_link_t          prev,
  input  logic signed [wmm_pkg::VAL_W-1:0] next_val,
  output wmm_pkg::cell_link_t          link
);
  import wmm_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    gt;

  assign gt = valid_r && (val_r > ctrl.ins_val);

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.ins) begin
      if (prev.gt) begin
        val_nxt   = prev.val;
        valid_nxt = 1'b1;
      end else if (prev.valid && (gt || !valid_r)) begin
        val_nxt   = ctrl.ins_val;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.shift) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign link.val   = val_r;

endmodule

/* design/window_median_with_missing.sv */
// a result: after the last request of a window the median is shifted to cell zero and then
// registered as the result (the empty value when nothing was stored)
// throughput: one request per cycle inside a window; input stalls from the last request
// until the median enters the result register, longer while an earlier result is held
// the chain of MAX_POINTS cells sorts on load; the median is shifted to cell zero
// reset: synchronous active low, clears counts, cell valid bits and result valid, and sets config to its reset values
module window_median_with_missing #(
  parameter int MAX_POINTS = wmm_pkg::MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  wmm_pkg::in_req_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output wmm_pkg::out_req_t         out_data,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [wmm_pkg::VAL_W-1:0] cfg_wdata
);
  import wmm_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_POINTS);

  // configuration
  logic                    miss_low_r;
  logic signed [VAL_W-1:0] fill_r;
  logic signed [VAL_W-1:0] empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_low_r <= 1'b0;
      fill_r     <= FILL_RST;
      empty_r    <= EMPTY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MISSING_AS_LOW: miss_low_r <= cfg_wdata[0];
        CFG_FILL_VALUE:     fill_r     <= cfg_wdata;
        CFG_EMPTY_VALUE:    empty_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [CNT_OUT_W-1:0]    miss_r, miss_nxt;
  logic                    drop_r, drop_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_req_t                out_r, out_nxt;

  logic                    in_acc;
  logic                    do_store;
  logic                    has_room;
  logic                    fin;
  logic signed [VAL_W-1:0] store_val;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
  cell_ctrl_t              ctrl;
  cell_link_t              links [MAX_POINTS];

  assign in_acc    = in_valid && !in_stall;
  assign do_store  = !in_data.is_missing || miss_low_r;
  assign store_val = in_data.is_missing ? fill_r : in_data.sample;
  assign has_room  = cnt_r < MAX_C;
  assign fin       = (state_r == ST_SEEK) && (rem_r == '0) && (!out_valid_r || !out_stall);
  assign cnt_ext   = {{CNT_OUT_W{1'b0}}, cnt_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_data.last) begin
          state_nxt = ST_SEEK;
        end
      end
      ST_SEEK: begin
        if (fin) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall      = 1'b1;
    ctrl.ins      = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.clr      = 1'b0;
    ctrl.ins_val  = store_val;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    miss_nxt      = miss_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_acc) begin
          if (in_data.is_missing && (miss_r != MISS_MAX)) begin
            miss_nxt = miss_r + 1'b1;
          end
          if (do_store) begin
            if (has_room) begin
              ctrl.ins = 1'b1;
              cnt_nxt  = cnt_r + 1'b1;
            end else begin
              drop_nxt = 1'b1;
            end
          end
          if (cnt_nxt == '0) begin
            rem_nxt = '0;
          end else begin
            rem_nxt = (cnt_nxt - 1'b1) >> 1;
          end
        end
      end
      ST_SEEK: begin
        if (rem_r != '0) begin
          ctrl.shift = 1'b1;
          rem_nxt    = rem_r - 1'b1;
        end else if (fin) begin
          ctrl.clr              = 1'b1;
          out_valid_nxt         = 1'b1;
          out_nxt.median        = (cnt_r == '0) ? empty_r : links[0].val;
          out_nxt.stored_count  = cnt_ext[CNT_OUT_W-1:0];
          out_nxt.missing_count = miss_r;
          out_nxt.overflow      = drop_r;
          cnt_nxt               = '0;
          miss_nxt              = '0;
          drop_nxt              = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      rem_r       <= '0;
      miss_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      miss_r      <= miss_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sorting chain, ascending from cell zero
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    cell_link_t              prev;
    logic signed [VAL_W-1:0] next_val;
    if (i == 0) begin : g_head
      assign prev.valid = 1'b1;
      assign prev.gt    = 1'b0;
      assign prev.val   = '0;
    end else begin : g_body
      assign prev = links[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_tail
      assign next_val = links[i].val;
    end else begin : g_mid
      assign next_val = links[i+1].val;
    end
    wmm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .prev     (prev),
      .next_val (next_val),
      .link     (links[i])
    );
  end

endmodule

/* design/wmm_checker.sv */
// port-level checks for the window median block, bound to the top level
// depends on wmm_pkg and window_median_with_missing
module wmm_checker #(
  parameter int MAX_POINTS = wmm_pkg::MAX_POINTS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input wmm_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input wmm_pkg::out_req_t out_data
);
  import wmm_pkg::*;

  localparam logic [CNT_OUT_W-1:0] FULL_C = CNT_OUT_W'(MAX_POINTS);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // window end stops input until the median is out
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input taken after window end");

  // a new result only follows a window end
  a_rose_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a window end");

  // dropped samples only with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.stored_count == FULL_C)
    else $error("overflow flagged with store not full");

endmodule

bind window_median_with_missing wmm_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_wmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
